/* design/fan_pwm_tach_stall_monitor_defines.svh */
// Assertion macros shared by the fan PWM and tachometer monitor RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef FAN_PWM_TACH_STALL_MONITOR_DEFINES_SVH
`define FAN_PWM_TACH_STALL_MONITOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpts check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define FPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fpts check failed one cycle later");

// The expression must never be true out of reset.
`define FPTS_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("fpts forbidden condition seen");

`endif

/* design/fpts_pkg.sv */
// Shared types and constants for the fan PWM, tachometer and stall monitor.
// Depends on nothing; imported by the register block and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fpts_pkg;

    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_ADDR_BITS = 5;

    localparam logic [CFG_IDX_BITS-1:0] REG_DUTY            = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PWM_PERIOD      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_PERIODS  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TACH_DELAY      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STALL_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STALL_LIMIT     = 3'd5;

    localparam logic [7:0]  RST_DUTY            = 8'd0;
    localparam logic [7:0]  RST_PWM_PERIOD      = 8'd100;
    localparam logic [9:0]  RST_WINDOW_PERIODS  = 10'd400;
    localparam logic [9:0]  RST_TACH_DELAY      = 10'd100;
    localparam logic [15:0] RST_STALL_THRESHOLD = 16'd20;
    localparam logic [7:0]  RST_STALL_LIMIT     = 8'd200;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef struct packed {
        logic [7:0]  duty;
        logic [7:0]  pwm_period;
        logic [9:0]  window_periods;
        logic [9:0]  tach_delay;
        logic [15:0] stall_threshold;
        logic [7:0]  stall_limit;
    } cfg_t;

endpackage

`default_nettype wire

/* design/fpts_regs.sv */
// APB-style configuration register block for the fan monitor.
// Depends on fpts_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module fpts_regs
    import fpts_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    output cfg_t                          cfg
);

    cfg_t                    cfg_reg;
    cfg_t                    cfg_next;
    logic                    wr_en;
    logic [CFG_IDX_BITS-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[CFG_ADDR_BITS-1:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_DUTY:            cfg_next.duty            = pwdata[7:0];
                REG_PWM_PERIOD:      cfg_next.pwm_period      = pwdata[7:0];
                REG_WINDOW_PERIODS:  cfg_next.window_periods  = pwdata[9:0];
                REG_TACH_DELAY:      cfg_next.tach_delay      = pwdata[9:0];
                REG_STALL_THRESHOLD: cfg_next.stall_threshold = pwdata[15:0];
                REG_STALL_LIMIT:     cfg_next.stall_limit     = pwdata[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DUTY:            prdata = {24'd0, cfg_reg.duty};
            REG_PWM_PERIOD:      prdata = {24'd0, cfg_reg.pwm_period};
            REG_WINDOW_PERIODS:  prdata = {22'd0, cfg_reg.window_periods};
            REG_TACH_DELAY:      prdata = {22'd0, cfg_reg.tach_delay};
            REG_STALL_THRESHOLD: prdata = {16'd0, cfg_reg.stall_threshold};
            REG_STALL_LIMIT:     prdata = {24'd0, cfg_reg.stall_limit};
            default:             prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.duty            <= RST_DUTY;
            cfg_reg.pwm_period      <= RST_PWM_PERIOD;
            cfg_reg.window_periods  <= RST_WINDOW_PERIODS;
            cfg_reg.tach_delay      <= RST_TACH_DELAY;
            cfg_reg.stall_threshold <= RST_STALL_THRESHOLD;
            cfg_reg.stall_limit     <= RST_STALL_LIMIT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/fan_pwm_tach_stall_monitor.sv */
// A result reaches the m_ side in the cycle after its request is accepted.
// Throughput: one request per cycle; s_tready is high whenever the result register
// is empty or its result is taken in the same cycle, so only m_tready sets the rate.
// Reset (aresetn low, synchronous) clears all counters, sets the pin level high,
// empties the result register and restores every configuration register.
// Top level of the fan PWM, tachometer and stall monitor; uses fpts_pkg and fpts_regs.
`timescale 1ns / 1ps
`default_nettype none
`include "fan_pwm_tach_stall_monitor_defines.svh"

module fan_pwm_tach_stall_monitor
    import fpts_pkg::*;
#(
    parameter int SPEED_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]              pwdata,
    output logic      [31:0]              prdata,
    output logic                          pready,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,  // [0] tach_level, [7:1] zero
    input  wire logic                     s_tuser,  // [0] op
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic      [23:0]              m_tdata   // [0] pwm_level, [16:1] speed_count,
                                                    // [17] speed_updated,
                                                    // [18] stall_fault, [23:19] zero
);

    localparam int SPEED_EXT = (SPEED_BITS > 16) ? SPEED_BITS : 16;

    cfg_t cfg;

    fpts_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic                  pin_reg,      pin_next;
    logic [7:0]            period_reg,   period_next;
    logic [9:0]            window_reg,   window_next;
    logic [SPEED_BITS-1:0] pulse_reg,    pulse_next;
    logic [SPEED_BITS-1:0] latched_reg,  latched_next;
    logic                  prev_tach_reg, prev_tach_next;
    logic                  qbusy_reg,    qbusy_next;
    logic [9:0]            qcount_reg,   qcount_next;
    logic [8:0]            fail_reg,     fail_next;
    logic                  m_valid_reg;
    logic [23:0]           m_data_reg,   m_data_next;

    logic                  accept;
    logic                  op;
    logic                  tach;
    logic [7:0]            pc_inc;
    logic [9:0]            wc_inc;
    logic [9:0]            qc_inc;
    logic [8:0]            fc_inc;
    logic                  wrap_period;
    logic                  wrap_window;
    logic                  sample;
    logic [SPEED_BITS-1:0] pulse_base;
    logic                  fault;
    logic                  low_speed;
    logic [SPEED_EXT-1:0]  latched_ext;
    logic [SPEED_EXT-1:0]  thr_ext;
    logic [SPEED_EXT-1:0]  lat_next_ext;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op       = s_tuser;
    assign tach     = s_tdata[0];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign pc_inc      = period_reg + 8'd1;
    assign wc_inc      = window_reg + 10'd1;
    assign qc_inc      = (qcount_reg != 10'h3FF) ? qcount_reg + 10'd1 : qcount_reg;
    assign fc_inc      = fail_reg + 9'd1;
    assign wrap_period = (pc_inc >= cfg.pwm_period) || (pc_inc == 8'd0);
    assign wrap_window = wrap_period
                         && ((wc_inc >= cfg.window_periods) || (wc_inc == 10'd0));
    assign sample      = qbusy_reg && (qc_inc >= cfg.tach_delay);
    assign pulse_base  = wrap_window ? '0 : pulse_reg;
    assign latched_ext = SPEED_EXT'(latched_reg);
    assign thr_ext     = SPEED_EXT'(cfg.stall_threshold);
    assign low_speed   = latched_ext < thr_ext;

    always_comb begin
        pin_next       = pin_reg;
        period_next    = period_reg;
        window_next    = window_reg;
        pulse_next     = pulse_reg;
        latched_next   = latched_reg;
        prev_tach_next = prev_tach_reg;
        qbusy_next     = qbusy_reg;
        qcount_next    = qcount_reg;
        fail_next      = fail_reg;
        fault          = 1'b0;
        if (op == OP_TICK) begin
            pin_next    = (period_reg < cfg.duty) ? 1'b0 : 1'b1;
            period_next = wrap_period ? 8'd0 : pc_inc;
            if (wrap_period) begin
                window_next = wrap_window ? 10'd0 : wc_inc;
            end
            latched_next = wrap_window ? pulse_reg : latched_reg;
            pulse_next   = pulse_base;
            if (qbusy_reg) begin
                qcount_next = qc_inc;
                if (sample) begin
                    qbusy_next = 1'b0;
                    if (tach && !(&pulse_base)) begin
                        pulse_next = pulse_base + SPEED_BITS'(1);
                    end
                end
            end else if (tach && !prev_tach_reg) begin
                qbusy_next  = 1'b1;
                qcount_next = 10'd0;
            end
            prev_tach_next = tach;
        end else begin
            if (low_speed) begin
                if (fc_inc > {1'b0, cfg.stall_limit}) begin
                    fail_next = {1'b0, cfg.stall_limit};
                    fault     = 1'b1;
                end else begin
                    fail_next = fc_inc;
                end
            end else begin
                fail_next = 9'd0;
            end
        end
    end

    assign lat_next_ext = SPEED_EXT'(latched_next);
    assign m_data_next  = {5'd0, fault, (op == OP_TICK) && wrap_window,
                           lat_next_ext[15:0], pin_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg       <= 1'b1;
            period_reg    <= 8'd0;
            window_reg    <= 10'd0;
            pulse_reg     <= '0;
            latched_reg   <= '0;
            prev_tach_reg <= 1'b0;
            qbusy_reg     <= 1'b0;
            qcount_reg    <= 10'd0;
            fail_reg      <= 9'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                pin_reg       <= pin_next;
                period_reg    <= period_next;
                window_reg    <= window_next;
                pulse_reg     <= pulse_next;
                latched_reg   <= latched_next;
                prev_tach_reg <= prev_tach_next;
                qbusy_reg     <= qbusy_next;
                qcount_reg    <= qcount_next;
                fail_reg      <= fail_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    `FPTS_ASSERT_NEVER(a_period_in_range, aclk, aresetn, period_reg == 8'hFF)
    `FPTS_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid_reg, s_tready)
    `FPTS_ASSERT_NEXT(a_window_end_clears, aclk, aresetn,
        accept && (op == OP_TICK) && wrap_window,
        (window_reg == 10'd0) && (period_reg == 8'd0) && (pulse_reg <= 1))
    `FPTS_ASSERT_NEXT(a_fault_saturates, aclk, aresetn,
        accept && (op == OP_CHECK) && fault,
        (fail_reg == {1'b0, cfg.stall_limit}) && m_tdata[18])
    `FPTS_ASSERT_NEXT(a_check_keeps_tick_state, aclk, aresetn,
        accept && (op == OP_CHECK),
        $stable(period_reg) && $stable(window_reg) && $stable(pulse_reg)
        && $stable(qbusy_reg))

endmodule

`default_nettype wire
